/* design/planar_sprite_run_encoder_macros.svh */
// Assertion macros used by the encoder back end.
`ifndef PLANAR_SPRITE_RUN_ENCODER_MACROS_SVH
`define PLANAR_SPRITE_RUN_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define PSRE_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("psre: check failed");
`define PSRE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psre: check failed");
`else
`define PSRE_ASSERT(name, clk, rst_n, prop)
`define PSRE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

`endif

/* design/psre_pkg.sv */
`timescale 1ns / 1ps
package psre_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int NUM_SLOTS     = 4;

	// Write slots produced by one pixel, in stream order.
	localparam int SLOT_RUN   = 0;  // header of the run that this pixel closes
	localparam int SLOT_PIXEL = 1;  // opaque pixel byte
	localparam int SLOT_TAIL  = 2;  // copy header closed at a row or plane end
	localparam int SLOT_END   = 3;  // end-of-plane word

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 12;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSPARENT  = 2'd3;

	localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd320;
	localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd200;
	localparam logic [11:0] SCREEN_WIDTH_RST = 12'd320;
	localparam logic [7:0]  TRANSPARENT_RST  = 8'd254;

	localparam logic [15:0] TAG_END  = 16'h0000;
	localparam logic [15:0] TAG_SKIP = 16'h4000;
	localparam logic [15:0] TAG_COPY = 16'hC000;
	localparam logic [14:0] RUN_LIMIT = 15'h3FF0;
	localparam logic [14:0] COUNT_MAX = 15'h3FFF;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]       slot_valid;
		logic [NUM_SLOTS-1:0][15:0] slot_data;
	} bundle_t;

endpackage

/* design/psre_front.sv */
`timescale 1ns / 1ps
module psre_front #(
	parameter int ADDR_BITS = psre_pkg::ADDR_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	input  logic [7:0]                                  pixel,
	input  logic                                        full,
	input  logic                                        cfg_valid,
	input  logic [psre_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
	input  logic [psre_pkg::CFG_DATA_BITS-1:0]          cfg_data,
	output logic                                        enq,
	output psre_pkg::bundle_t                           bundle,
	output logic [psre_pkg::NUM_SLOTS-1:0][ADDR_BITS-1:0] slot_addr
);
	import psre_pkg::*;

	logic [11:0] image_width_q, image_height_q, screen_width_q;
	logic [7:0]  transparent_q;

	logic [1:0]           plane_q;
	logic [11:0]          row_q;
	logic [12:0]          col_q;
	logic [ADDR_BITS-1:0] ha_q, na_q;
	logic                 skip_q, rc_big_q, pstart_q;
	logic [14:0]          rc_q;

	logic [11:0] w, h;
	logic        transp, skip0, rc0_big, lim0, close1, skip1, data_v;
	logic [14:0] rc0, rc1, rc2, rc3, gap;
	logic [13:0] sat0;
	logic [13:0] j;
	logic [16:0] diff;
	logic        rowend, narrow, gap_big, planeend, tail_v, skip3, big3;
	logic [11:0] row_n;
	logic [1:0]  plane_n;
	logic [ADDR_BITS-1:0] ha1, na1, na2, ha2, na3, ha3, na4;
	logic        accept;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			screen_width_q <= SCREEN_WIDTH_RST;
			transparent_q  <= TRANSPARENT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_TRANSPARENT:  transparent_q  <= cfg_data[7:0];
			endcase
		end
	end

	always_comb begin
		w = (image_width_q < 12'd4) ? 12'd4 : image_width_q;
		h = (image_height_q == 12'd0) ? 12'd1 : image_height_q;
		transp = (pixel == transparent_q);

		skip0   = pstart_q ? transp : skip_q;
		rc0     = pstart_q ? 15'd0 : rc_q;
		rc0_big = pstart_q ? 1'b0 : rc_big_q;
		lim0    = rc0_big || (rc0 >= RUN_LIMIT);
		close1  = (transp != skip0) || lim0;
		sat0    = (rc0_big || rc0 > COUNT_MAX) ? COUNT_MAX[13:0] : rc0[13:0];

		skip1  = close1 ? transp : skip0;
		rc1    = close1 ? 15'd0 : rc0;
		data_v = !skip1;
		rc2    = rc1 + 15'd1;

		j       = {1'b0, col_q} + 14'd4;
		rowend  = (j >= {2'b00, w});
		narrow  = (w < screen_width_q);
		diff    = {5'b0, screen_width_q} + 17'd3 - {3'b0, j};
		gap     = diff[16:2];
		// a column past the screen edge makes the gap wrap to a huge count
		gap_big = ({1'b0, j} > ({3'b0, screen_width_q} + 15'd3));

		row_n    = row_q + 12'd1;
		planeend = rowend && (row_n >= h);
		plane_n  = plane_q + 2'd1;
		tail_v   = rowend && !skip1 && (narrow || planeend);

		skip3 = skip1;
		rc3   = rc2;
		big3  = 1'b0;
		if (rowend && narrow) begin
			if (skip1) begin
				rc3 = rc2 + gap;
			end else begin
				skip3 = 1'b1;
				rc3   = gap;
				big3  = gap_big;
			end
		end

		// address chain through the slots in stream order
		ha1 = close1 ? na_q : ha_q;
		na1 = close1 ? na_q + ADDR_BITS'(2) : na_q;
		na2 = data_v ? na1 + ADDR_BITS'(1) : na1;
		ha2 = tail_v ? na2 : ha1;
		na3 = tail_v ? na2 + ADDR_BITS'(2) : na2;
		ha3 = planeend ? na3 : ha2;
		na4 = planeend ? na3 + ADDR_BITS'(2) : na3;

		bundle.slot_valid[SLOT_RUN]   = close1;
		bundle.slot_valid[SLOT_PIXEL] = data_v;
		bundle.slot_valid[SLOT_TAIL]  = tail_v;
		bundle.slot_valid[SLOT_END]   = planeend;
		bundle.slot_data[SLOT_RUN]    = (skip0 ? TAG_SKIP : TAG_COPY) | {2'b00, sat0};
		bundle.slot_data[SLOT_PIXEL]  = {8'h00, pixel};
		bundle.slot_data[SLOT_TAIL]   = TAG_COPY | {2'b00, rc2[13:0]};
		bundle.slot_data[SLOT_END]    = TAG_END;
		slot_addr[SLOT_RUN]   = ha_q;
		slot_addr[SLOT_PIXEL] = na1;
		slot_addr[SLOT_TAIL]  = ha1;
		slot_addr[SLOT_END]   = ha2;
	end

	// drop pixels that cause no write
	assign enq = accept && (|bundle.slot_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ha_q     <= '0;
			na_q     <= ADDR_BITS'(2);
			skip_q   <= 1'b0;
			rc_q     <= '0;
			rc_big_q <= 1'b0;
			pstart_q <= 1'b1;
		end else if (accept) begin
			skip_q   <= skip3;
			rc_q     <= rc3;
			rc_big_q <= big3;
			pstart_q <= planeend;
			if (rowend) begin
				row_q <= planeend ? 12'd0 : row_n;
				col_q <= {11'b0, planeend ? plane_n : plane_q};
			end else begin
				col_q <= j[12:0];
			end
			if (planeend) begin
				plane_q <= plane_n;
			end
			// a new sprite restarts the stream at offset zero
			if (planeend && plane_n == 2'd0) begin
				ha_q <= '0;
				na_q <= ADDR_BITS'(2);
			end else begin
				ha_q <= ha3;
				na_q <= na4;
			end
		end
	end

endmodule

/* design/psre_queue.sv */
`timescale 1ns / 1ps
module psre_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = psre_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq,
	input  logic [WIDTH-1:0] enq_data,
	input  logic             deq,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	import psre_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             do_enq, do_deq;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_q];
	assign do_enq     = enq && !full;
	assign do_deq     = deq && head_valid;

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wr_q] <= enq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_enq) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_deq) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_enq && !do_deq) begin
				count_q <= count_q + CW'(1);
			end else if (do_deq && !do_enq) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/psre_back.sv */
`timescale 1ns / 1ps
`include "planar_sprite_run_encoder_macros.svh"
module psre_back #(
	parameter int ADDR_BITS = psre_pkg::ADDR_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          head_valid,
	input  psre_pkg::bundle_t                             head,
	input  logic [psre_pkg::NUM_SLOTS-1:0][ADDR_BITS-1:0] head_addr,
	output logic                                          deq,
	input  logic                                          pop,
	output logic                                          empty,
	output logic [15:0]                                   write_address,
	output logic [15:0]                                   write_data,
	output logic                                          is_word,
	output logic                                          last
);
	import psre_pkg::*;

	logic [NUM_SLOTS-1:0] done_q, remaining, pick;
	logic [1:0]           pick_idx;
	logic                 pick_last, advance;
	logic                 out_valid_q;
	logic [ADDR_BITS+15:0] addr_ext;

	assign remaining = head.slot_valid & ~done_q;
	assign pick      = remaining & (~remaining + NUM_SLOTS'(1));
	assign pick_last = ((remaining & ~pick) == '0);
	assign advance   = head_valid && (!out_valid_q || pop);
	assign deq       = advance && pick_last;

	always_comb begin
		priority if (remaining[SLOT_RUN])   pick_idx = 2'(SLOT_RUN);
		else if (remaining[SLOT_PIXEL])     pick_idx = 2'(SLOT_PIXEL);
		else if (remaining[SLOT_TAIL])      pick_idx = 2'(SLOT_TAIL);
		else                                pick_idx = 2'(SLOT_END);
	end

	assign addr_ext = {16'h0000, head_addr[pick_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				// clear the mask once the last slot of this pixel leaves
				done_q      <= pick_last ? '0 : (done_q | pick);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			write_address <= addr_ext[15:0];
			write_data    <= head.slot_data[pick_idx];
			is_word       <= (pick_idx != 2'(SLOT_PIXEL));
			last          <= pick_last;
		end
	end

	assign empty = !out_valid_q;

	`PSRE_ASSERT_IMP(a_mask_idle, clk, arst_n, !head_valid, done_q == '0)
	`PSRE_ASSERT(a_mask_subset, clk, arst_n, (done_q & ~head.slot_valid) == '0 || !head_valid)
	`PSRE_ASSERT_IMP(a_slot_left, clk, arst_n, head_valid, remaining != '0)

endmodule

/* design/planar_sprite_run_encoder.sv */
`timescale 1ns / 1ps
// Planar sprite run-length encoder. Pixels are pushed one per clock in plane
// order while full is low and come out as stream writes (header words and
// pixel bytes) in the order they belong in memory. The front end classifies
// one pixel per cycle while the queue is not full and turns it into zero to
// four writes; a four-entry pixel queue sits between it and the write
// serializer, which drains one write per cycle while its output is popped or
// empty. A pixel's writes leave one after another, and the queue absorbs
// bursts at run, row and plane ends. Configuration writes are always ready;
// change them only while the encoder is idle.
module planar_sprite_run_encoder #(
	parameter int ADDR_BITS = psre_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          pixel,
	output logic                                empty,
	input  logic                                pop,
	output logic [15:0]                         write_address,
	output logic [15:0]                         write_data,
	output logic                                is_word,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [psre_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [psre_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import psre_pkg::*;

	localparam int QW = $bits(bundle_t) + NUM_SLOTS * ADDR_BITS;

	logic                                 enq, deq, head_valid;
	bundle_t                              bundle, head;
	logic [NUM_SLOTS-1:0][ADDR_BITS-1:0]  slot_addr, head_addr;
	logic [QW-1:0]                        head_data;

	assign cfg_ready = 1'b1;

	psre_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.enq       (enq),
		.bundle    (bundle),
		.slot_addr (slot_addr)
	);

	psre_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (enq),
		.enq_data   ({slot_addr, bundle}),
		.deq        (deq),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign {head_addr, head} = head_data;

	psre_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.head_addr     (head_addr),
		.deq           (deq),
		.pop           (pop),
		.empty         (empty),
		.write_address (write_address),
		.write_data    (write_data),
		.is_word       (is_word),
		.last          (last)
	);

endmodule
